[design/prs_pkg.sv]
`timescale 1ns / 1ps
package prs_pkg;
    localparam int MAX_SUBSPACES = 16;
    localparam int MAX_CODEWORDS = 256;
    localparam int MAX_SUB_WIDTH = 16;
    localparam int HEAP_DEPTH    = 64;

    localparam int BOOK_AW  = 16;
    localparam int VEC_AW   = 8;
    localparam int TAB_AW   = 12;
    localparam int HEAP_AW  = 6;
    localparam int FILL_W   = 7;
    localparam int DIST_W   = 42;
    localparam int TAB_W    = 38;
    localparam int ID_W     = 31;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 9;

    localparam logic [2:0] ACT_BOOK   = 3'd0;
    localparam logic [2:0] ACT_QUERY  = 3'd1;
    localparam logic [2:0] ACT_CENT   = 3'd2;
    localparam logic [2:0] ACT_BUILD  = 3'd3;
    localparam logic [2:0] ACT_SCORE  = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;
    localparam logic [2:0] ACT_DRAIN  = 3'd6;

    localparam logic [CFG_IW-1:0] REG_SUBSPACES = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CODEWORDS = 2'd1;
    localparam logic [CFG_IW-1:0] REG_WIDTH     = 2'd2;
    localparam logic [CFG_IW-1:0] REG_KEEP      = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] elem_index;
        logic signed [15:0] elem_value;
        logic [63:0] codes_low;
        logic [63:0] codes_high;
        logic [ID_W-1:0] vector_id;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] entry_distance;
        logic [ID_W-1:0]   entry_id;
        logic              entry_valid;
        logic              last;
    } t_out_item;
endpackage

[design/prs_stream_if.sv]
`timescale 1ns / 1ps
interface prs_in_if;
    logic                valid;
    logic                ready;
    prs_pkg::t_in_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface prs_out_if;
    logic                valid;
    logic                ready;
    prs_pkg::t_out_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/pq_residual_scan_top_n.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake       Payload
// s_in      in   valid/ready     action, elem_index, elem_value, codes, vector_id
// m_out     out  valid/ready     entry_distance, entry_id, entry_valid, last
// cfg       in   i_cfg_we        i_cfg_index, i_cfg_data
//
// A score does one table read per subspace, then sifts an accepted entry up or
// down the heap level by level and ends with a closing write, over the
// single-port heap memories.
// A build does one codebook read per element and one table write per codeword.
// A drain reads and emits one entry at a time, waiting while the output register is stalled.
// Reset is synchronous: heap fill, config and control clear; memories do not.
module pq_residual_scan_top_n (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [prs_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [prs_pkg::CFG_DW-1:0]  i_cfg_data,
    prs_in_if.sink                      s_in,
    prs_out_if.source                   m_out
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BUILD = 4'd1;
    localparam logic [3:0] S_BACC  = 4'd2;
    localparam logic [3:0] S_SCORE = 4'd3;
    localparam logic [3:0] S_SACC  = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_UPRD  = 4'd6;
    localparam logic [3:0] S_UPCMP = 4'd7;
    localparam logic [3:0] S_DNRD  = 4'd8;
    localparam logic [3:0] S_DNCMP = 4'd9;
    localparam logic [3:0] S_DRRD  = 4'd10;
    localparam logic [3:0] S_DROUT = 4'd11;
    localparam logic [3:0] S_DNRD2 = 4'd12;
    localparam logic [3:0] S_WAIT  = 4'd13;

    // Configuration registers
    logic [4:0] r_cfg_m, r_cfg_w;
    logic [8:0] r_cfg_k;
    logic [6:0] r_cfg_keep;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_m <= 5'd16; r_cfg_k <= 9'd256; r_cfg_w <= 5'd8; r_cfg_keep <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                prs_pkg::REG_SUBSPACES: r_cfg_m    <= i_cfg_data[4:0];
                prs_pkg::REG_CODEWORDS: r_cfg_k    <= i_cfg_data;
                prs_pkg::REG_WIDTH:     r_cfg_w    <= i_cfg_data[4:0];
                prs_pkg::REG_KEEP:      r_cfg_keep <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Clamped settings
    logic [4:0] nm, nw;
    logic [8:0] nk;
    logic [6:0] nkeep;
    always_comb begin
        nm    = (r_cfg_m == 5'd0) ? 5'd1 : ((r_cfg_m > 5'd16) ? 5'd16 : r_cfg_m);
        nw    = (r_cfg_w == 5'd0) ? 5'd1 : ((r_cfg_w > 5'd16) ? 5'd16 : r_cfg_w);
        nk    = (r_cfg_k == 9'd0) ? 9'd1 : ((r_cfg_k > 9'd256) ? 9'd256 : r_cfg_k);
        nkeep = (r_cfg_keep == 7'd0) ? 7'd1 : ((r_cfg_keep > 7'd64) ? 7'd64 : r_cfg_keep);
    end

    // Memories
    logic signed [15:0] book_mem [0:(1<<prs_pkg::BOOK_AW)-1];
    logic signed [15:0] qry_mem  [0:(1<<prs_pkg::VEC_AW)-1];
    logic signed [15:0] cen_mem  [0:(1<<prs_pkg::VEC_AW)-1];
    logic [prs_pkg::TAB_W-1:0]  tab_mem  [0:(1<<prs_pkg::TAB_AW)-1];
    logic [prs_pkg::DIST_W-1:0] hd_mem   [0:prs_pkg::HEAP_DEPTH-1];
    logic [prs_pkg::ID_W-1:0]   hi_mem   [0:prs_pkg::HEAP_DEPTH-1];

    logic [3:0]  r_state, n_state;
    prs_pkg::t_in_item r_item;
    logic [6:0]  r_fill;
    logic [4:0]  r_m;
    logic [8:0]  r_k;
    logic [4:0]  r_i;
    logic [19:0] r_bbase;          // (m*K+k)*W, below 2^20
    logic [41:0] r_acc;
    logic        r_rd_v;           // read issued last cycle
    logic [5:0]  r_pos;
    logic [6:0]  r_child;          // may point past the last entry
    logic [41:0] r_cur_d, r_a_d;
    logic [30:0] r_cur_id, r_a_id;
    logic [5:0]  r_a_pos;
    logic        r_has_r;
    logic [prs_pkg::DIST_W-1:0] r_hd_q;
    logic [prs_pkg::ID_W-1:0]   r_hi_q;
    logic [prs_pkg::TAB_W-1:0]  r_tab_q;
    logic signed [15:0] r_b_q, r_q_q, r_c_q;
    logic        r_out_v;
    prs_pkg::t_out_item r_out;

    // Memory ports, driven by the sequencer
    logic        book_we, q_we, c_we, tab_we, h_we;
    logic [15:0] book_ra;
    logic [7:0]  vec_ra;
    logic [11:0] tab_a;
    logic [5:0]  h_a;
    logic [41:0] h_wd;
    logic [30:0] h_wid;
    logic [37:0] tab_wd;

    always_ff @(posedge i_clk) begin
        if (book_we) book_mem[r_item.elem_index] <= r_item.elem_value;
        r_b_q <= book_mem[book_ra];
    end
    always_ff @(posedge i_clk) begin
        if (q_we) qry_mem[r_item.elem_index[7:0]] <= r_item.elem_value;
        r_q_q <= qry_mem[vec_ra];
    end
    always_ff @(posedge i_clk) begin
        if (c_we) cen_mem[r_item.elem_index[7:0]] <= r_item.elem_value;
        r_c_q <= cen_mem[vec_ra];
    end
    always_ff @(posedge i_clk) begin
        if (tab_we) tab_mem[tab_a] <= tab_wd;
        r_tab_q <= tab_mem[tab_a];
    end
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hd_mem[h_a] <= h_wd;
            hi_mem[h_a] <= h_wid;
        end
        r_hd_q <= hd_mem[h_a];
        r_hi_q <= hi_mem[h_a];
    end

    // Build datapath: residual minus codeword, squared
    logic signed [17:0] diff;
    logic [35:0] sq;
    always_comb begin
        diff = 18'(r_q_q) - 18'(r_c_q) - 18'(r_b_q);
        sq   = 36'(36'(diff) * 36'(diff));
    end

    // Running sum plus the square landing this cycle
    logic [41:0] build_sum;
    assign build_sum = r_acc + 42'(sq);

    // Code of the current subspace, saturated to K-1
    logic [7:0] code_raw;
    logic [8:0] code_sat;
    always_comb begin
        code_raw = r_m[3] ? r_item.codes_high[{r_m[2:0], 3'b000} +: 8]
                          : r_item.codes_low[{r_m[2:0], 3'b000} +: 8];
        code_sat = ({1'b0, code_raw} >= nk) ? nk - 9'd1 : {1'b0, code_raw};
    end

    logic [5:0] parent;
    assign parent = (r_pos - 6'd1) >> 1;

    assign s_in.ready = (r_state == S_IDLE);
    assign m_out.valid = r_out_v;
    assign m_out.payload = r_out;

    // Sequencer
    logic [6:0] n_fill;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (r_state == S_DROUT && n_state != S_DROUT) r_out_v <= 1'b1;
            else if (m_out.ready) r_out_v <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        book_we = 1'b0; q_we = 1'b0; c_we = 1'b0; tab_we = 1'b0; h_we = 1'b0;
        book_ra = r_bbase[15:0] + 16'(r_i);
        vec_ra  = 8'(r_m * nw + 9'(r_i));
        tab_a   = {r_m[3:0], r_k[7:0]};
        tab_wd  = build_sum[37:0];
        h_a     = r_pos;
        h_wd    = r_cur_d;
        h_wid   = r_cur_id;
        unique case (r_state)
            S_IDLE: if (s_in.valid) n_state = S_WAIT;
            S_WAIT: begin
                n_state = S_IDLE;
                unique case (r_item.action)
                    prs_pkg::ACT_BOOK:  book_we = 1'b1;
                    prs_pkg::ACT_QUERY: q_we = (r_item.elem_index < 16'd256);
                    prs_pkg::ACT_CENT:  c_we = (r_item.elem_index < 16'd256);
                    prs_pkg::ACT_BUILD: n_state = S_BUILD;
                    prs_pkg::ACT_SCORE: n_state = S_SCORE;
                    prs_pkg::ACT_CLEAR: n_fill = '0;
                    prs_pkg::ACT_DRAIN: n_state = S_DRRD;
                    default: ;
                endcase
            end
            S_BUILD: n_state = (r_i == nw - 5'd1) ? S_BACC : S_BUILD;
            S_BACC: begin
                tab_we = 1'b1;
                if (r_k == nk - 9'd1 && r_m == nm - 5'd1) n_state = S_IDLE;
                else n_state = S_BUILD;
            end
            S_SCORE: begin
                tab_a = {r_m[3:0], code_sat[7:0]};
                if (r_m == nm - 5'd1) n_state = S_SACC;
            end
            S_SACC: begin
                h_a = '0;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (r_fill < nkeep) begin
                    h_we = 1'b1; h_a = r_fill[5:0];
                    n_fill = r_fill + 7'd1;
                    n_state = (r_fill == 7'd0) ? S_IDLE : S_UPRD;
                end else if (r_cur_d < r_hd_q) begin
                    h_we = 1'b1; h_a = '0;
                    n_state = S_DNRD;
                end else n_state = S_IDLE;
            end
            S_UPRD: begin
                if (r_pos == 6'd0) begin
                    // reached the root: new item lands there
                    h_we = 1'b1; h_a = '0;
                    n_state = S_IDLE;
                end else begin
                    h_a = parent;
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                h_we = 1'b1; h_a = r_pos;
                if (r_hd_q >= r_cur_d) n_state = S_IDLE;
                else begin
                    // move parent down, new item goes on up
                    h_wd = r_hd_q; h_wid = r_hi_q;
                    n_state = S_UPRD;
                end
            end
            S_DNRD: begin
                if (r_child >= r_fill) begin
                    // no children: new item lands here
                    h_we = 1'b1; h_a = r_pos;
                    n_state = S_IDLE;
                end else begin
                    h_a = r_child[5:0];
                    n_state = S_DNRD2;
                end
            end
            S_DNRD2: begin
                h_a = r_child[5:0] + 6'd1;
                n_state = S_DNCMP;
            end
            S_DNCMP: begin
                // r_a holds left child, r_hd_q right child
                h_we = 1'b1; h_a = r_pos;
                if (!(r_a_d > r_cur_d) && !(r_has_r && r_hd_q > r_cur_d)) n_state = S_IDLE;
                else begin
                    if (r_has_r && r_hd_q > r_a_d) begin
                        h_wd = r_hd_q; h_wid = r_hi_q;
                    end else begin
                        h_wd = r_a_d; h_wid = r_a_id;
                    end
                    n_state = S_DNRD;
                end
            end
            S_DRRD: begin
                h_a = r_pos;
                n_state = S_DROUT;
            end
            S_DROUT: begin
                if (!r_out_v || m_out.ready) begin
                    if (r_fill == 7'd0 || 7'(r_pos) + 7'd1 >= r_fill) n_state = S_IDLE;
                    else n_state = S_DRRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (s_in.valid) begin
                r_item <= s_in.payload;
                r_m <= '0; r_k <= '0; r_i <= '0; r_bbase <= '0;
                r_pos <= '0;
            end
            S_BUILD: if (r_i != nw - 5'd1) r_i <= r_i + 5'd1;
            S_BACC: begin
                r_i <= '0;
                r_bbase <= r_bbase + 20'(nw);
                if (r_k == nk - 9'd1) begin
                    r_k <= '0; r_m <= r_m + 5'd1;
                end else r_k <= r_k + 9'd1;
            end
            S_SCORE: if (r_m != nm - 5'd1) r_m <= r_m + 5'd1;
            S_SACC: begin
                r_cur_d  <= r_acc + 42'(r_tab_q);
                r_cur_id <= r_item.vector_id;
            end
            S_DEC: begin
                r_pos   <= (r_fill < nkeep) ? r_fill[5:0] : 6'd0;
                r_child <= 7'd1;
            end
            S_UPCMP: if (r_hd_q < r_cur_d) r_pos <= parent;
            S_DNRD2: begin
                r_a_d <= r_hd_q; r_a_id <= r_hi_q; r_a_pos <= r_child[5:0];
                r_has_r <= (r_child + 7'd1) < r_fill;
            end
            S_DNCMP: begin
                r_pos   <= (r_has_r && r_hd_q > r_a_d) ? r_child[5:0] + 6'd1 : r_a_pos;
                r_child <= (r_has_r && r_hd_q > r_a_d) ? {r_child[5:0] + 6'd1, 1'b1}
                                                       : {r_a_pos, 1'b1};
            end
            S_DROUT: if (!r_out_v || m_out.ready) begin
                r_out.entry_distance <= (r_fill == 7'd0) ? '0 : r_hd_q;
                r_out.entry_id       <= (r_fill == 7'd0) ? '0 : r_hi_q;
                r_out.entry_valid    <= (r_fill != 7'd0);
                r_out.last <= (r_fill == 7'd0) || (7'(r_pos) + 7'd1 >= r_fill);
                r_pos <= r_pos + 6'd1;
            end
            default: ;
        endcase
    end

    // Accumulate reads landing from the previous cycle
    always_ff @(posedge i_clk) begin
        r_rd_v <= (r_state == S_BUILD) || (r_state == S_SCORE);
        if (r_state == S_IDLE || r_state == S_BACC) r_acc <= '0;
        else if (r_rd_v && r_state == S_BUILD) r_acc <= build_sum;
        else if (r_rd_v && r_state == S_SCORE) r_acc <= r_acc + 42'(r_tab_q);
    end

    // Assertions
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 7'(prs_pkg::HEAP_DEPTH)) else $error("heap fill over depth");
    a_out_only_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state) == S_DROUT) else $error("item outside drain");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> !tab_we && !h_we) else $error("memory write while idle");
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.entry_valid) |-> r_out.last) else $error("empty drain not last");
endmodule
